// ===== rtl/core/thse_pkg.sv =====
// Shared types and codes for the TCP handshake engine.
// No dependencies; imported by every module of the block.
package thse_pkg;

  localparam logic [1:0] OP_CONNECT = 2'd0;
  localparam logic [1:0] OP_LISTEN  = 2'd1;
  localparam logic [1:0] OP_SEGMENT = 2'd2;

  localparam logic [2:0] ST_CLOSED   = 3'd0;
  localparam logic [2:0] ST_LISTEN   = 3'd1;
  localparam logic [2:0] ST_SYN_SENT = 3'd2;
  localparam logic [2:0] ST_SYN_RCVD = 3'd3;
  localparam logic [2:0] ST_ESTAB    = 3'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_DROP    = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  typedef enum logic [2:0] {
    KIND_CONNECT,
    KIND_LISTEN,
    KIND_SEGMENT,
    KIND_DROP,
    KIND_REFUSE
  } kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic        seg_syn;
    logic        seg_ack_flag;
    logic [31:0] seg_seq_num;
    logic [31:0] seg_ack_num;
    logic        checksum_ok;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic        send_syn;
    logic        send_ack_flag;
    logic [31:0] send_seq;
    logic [31:0] send_ack_num;
    logic [2:0]  conn_state;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    kind_e       kind;
    logic        syn;
    logic        ack;
    logic [31:0] seq;
    logic [31:0] ackn;
  } cmd_t;

endpackage

// ===== rtl/core/thse_front.sv =====
// Front end: takes input requests and classifies them into commands.
// Depends on thse_pkg.
module thse_front (
  input  logic              in_valid_i,
  input  thse_pkg::in_item_t in_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output thse_pkg::cmd_t    cmd_o
);
  import thse_pkg::*;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    cmd_o.syn  = in_i.seg_syn;
    cmd_o.ack  = in_i.seg_ack_flag;
    cmd_o.seq  = in_i.seg_seq_num;
    cmd_o.ackn = in_i.seg_ack_num;
    unique case (in_i.op)
      OP_CONNECT: cmd_o.kind = KIND_CONNECT;
      OP_LISTEN:  cmd_o.kind = KIND_LISTEN;
      OP_SEGMENT: cmd_o.kind = in_i.checksum_ok ? KIND_SEGMENT : KIND_DROP;
      default:    cmd_o.kind = KIND_REFUSE;
    endcase
  end

endmodule

// ===== rtl/core/thse_queue.sv =====
// Small command queue between front and back ends.
// Depends on thse_pkg.
module thse_queue #(
  parameter int Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  thse_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output thse_pkg::cmd_t cmd_o
);
  import thse_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);
  localparam logic [PtrW-1:0] LastC  = PtrW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == DepthC);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastC) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastC) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/core/thse_back.sv =====
// Back end: connection state machine, sequence tracking and result register.
// Depends on thse_pkg.
module thse_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  thse_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  input  logic                cfg_valid_i,
  input  logic [31:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output thse_pkg::out_item_t out_o
);
  import thse_pkg::*;

  logic [2:0]  st_q, st_d;
  logic [31:0] snd_nxt_q, snd_nxt_d;
  logic [31:0] snd_una_q, snd_una_d;
  logic [31:0] rcv_nxt_q, rcv_nxt_d;
  logic [31:0] init_seq_q;
  logic [31:0] una_inc, seq_inc;
  logic        ack_match;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, res;

  assign pop_o       = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign una_inc     = snd_una_q + 32'd1;
  assign seq_inc     = cmd_i.seq + 32'd1;
  assign ack_match   = (cmd_i.ackn == una_inc);

  always_comb begin
    st_d      = st_q;
    snd_nxt_d = snd_nxt_q;
    snd_una_d = snd_una_q;
    rcv_nxt_d = rcv_nxt_q;
    res       = '0;
    res.status = STATUS_OK;
    unique case (cmd_i.kind)
      KIND_CONNECT: begin
        if (st_q == ST_CLOSED) begin
          snd_una_d    = init_seq_q;
          snd_nxt_d    = init_seq_q + 32'd1;
          st_d         = ST_SYN_SENT;
          res.send_valid = 1'b1;
          res.send_syn   = 1'b1;
          res.send_seq   = init_seq_q;
        end else begin
          res.status = STATUS_REFUSED;
        end
      end
      KIND_LISTEN: begin
        if (st_q == ST_CLOSED) begin
          snd_una_d = init_seq_q;
          snd_nxt_d = init_seq_q;
          st_d      = ST_LISTEN;
        end else begin
          res.status = STATUS_REFUSED;
        end
      end
      KIND_DROP:   res.status = STATUS_DROP;
      KIND_REFUSE: res.status = STATUS_REFUSED;
      KIND_SEGMENT: begin
        unique case (st_q) inside
          ST_CLOSED, ST_ESTAB: ;
          ST_LISTEN: begin
            if (cmd_i.syn) begin
              rcv_nxt_d         = seq_inc;
              st_d              = ST_SYN_RCVD;
              res.send_valid    = 1'b1;
              res.send_syn      = 1'b1;
              res.send_ack_flag = 1'b1;
              res.send_seq      = snd_nxt_q;
              res.send_ack_num  = seq_inc;
              snd_nxt_d         = snd_nxt_q + 32'd1;
            end
          end
          ST_SYN_SENT: begin
            if (cmd_i.syn && cmd_i.ack) begin
              if (!ack_match) begin
                res.status = STATUS_DROP;
              end else begin
                snd_una_d         = una_inc;
                rcv_nxt_d         = seq_inc;
                st_d              = ST_ESTAB;
                res.send_valid    = 1'b1;
                res.send_ack_flag = 1'b1;
                res.send_seq      = snd_nxt_q;
                res.send_ack_num  = seq_inc;
              end
            end
          end
          ST_SYN_RCVD: begin
            if (cmd_i.ack) begin
              if (!ack_match) begin
                res.status = STATUS_DROP;
              end else begin
                snd_una_d = una_inc;
                st_d      = ST_ESTAB;
              end
            end
          end
          default: res.status = STATUS_DROP;
        endcase
      end
      default: res.status = STATUS_REFUSED;
    endcase
    res.conn_state = st_d;
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLOSED;
      snd_nxt_q   <= '0;
      snd_una_q   <= '0;
      rcv_nxt_q   <= '0;
      init_seq_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        init_seq_q <= cfg_data_i;
      end
      if (pop_o) begin
        st_q      <= st_d;
        snd_nxt_q <= snd_nxt_d;
        snd_una_q <= snd_una_d;
        rcv_nxt_q <= rcv_nxt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

endmodule

// ===== rtl/core/tcp_handshake_engine_core.sv =====
// TCP three-way handshake engine, top level: front end, command queue, back end.
// Depends on thse_pkg, thse_front, thse_queue, thse_back.
// An accepted request is queued, then popped into the back end's result register.
// Throughput: one request per cycle without output stall; state updates per pop.
// Reset: state closed, sequence numbers and initial_seq zero, queue and output empty.
module tcp_handshake_engine_core #(
  parameter int QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  thse_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output thse_pkg::out_item_t out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);
  import thse_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t front_cmd, back_cmd;

  assign cfg_ready_o = 1'b1;

  thse_front u_front (
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (q_push),
    .cmd_o      (front_cmd)
  );

  thse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (back_cmd)
  );

  thse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (back_cmd),
    .pop_o       (q_pop),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
